>>> hdl/fhdau_pkg.sv
`timescale 1ns / 1ps

package fhdau_pkg;

    // Action codes
    localparam logic [2:0] ACT_START    = 3'd0;
    localparam logic [2:0] ACT_SEEK     = 3'd1;
    localparam logic [2:0] ACT_XLATE    = 3'd2;
    localparam logic [2:0] ACT_XLATE_WR = 3'd3;
    localparam logic [2:0] ACT_ADVANCE  = 3'd4;
    localparam logic [2:0] ACT_SENSE    = 3'd5;

    // Register indexes on the configuration port
    localparam logic REG_MODEL      = 1'b0;
    localparam logic REG_WRITE_LOCK = 1'b1;

    // Field widths
    localparam int ADDR_W   = 15;
    localparam int WADDR_W  = 21;
    localparam int TRK_W    = 10;
    localparam int SEC_W    = 7;
    localparam int LOCK_W   = 16;
    localparam int SLEN_W   = 3;

    // Geometry
    localparam int M0_SECTORS = 82;
    localparam int M0_TRACKS  = 64;
    localparam int M1_SECTORS = 12;
    localparam int M1_TRACKS  = 512;

    localparam logic [SLEN_W-1:0] SENSE_LEN_M0 = 3'd4;
    localparam logic [SLEN_W-1:0] SENSE_LEN_M1 = 3'd3;

    // Words in one sector and number of track groups sharing the lock switches
    localparam int WORDS_PER_SECTOR = 256;
    localparam int LOCK_GROUPS      = 16;

    localparam int STAT_PROTECT_BIT = 4;
    localparam int STAT_BAD_BIT     = 5;

endpackage

>>> hdl/fixed_head_disk_address_unit.sv
`timescale 1ns / 1ps

// Disk address and status unit for a head-per-track controller with two
// geometries (model 0: 82 sectors x 64 tracks, model 1: 12 sectors x 512
// tracks). Each request carries one action (start, seek, translate, translate
// for write, advance, sense) and yields exactly one response carrying the
// word address, the check bits, the sense bytes and the status byte. The unit
// takes one request per clock cycle. A request waits in the request register
// and is loaded into the response register as soon as that register is empty
// or its response is being taken. The response register decouples the two
// sides, so a new request is taken while a finished response waits; only when
// both registers are full and the response is stalled does req_ready drop.
// The action, the address register update and the response are all formed
// combinationally between the request register and the response register.
// The model and write_lock registers sit on an APB-style port at byte
// addresses 0 and 4; write them only while no request is in flight. No
// clearing pass after reset: the unit is ready at once.
module fixed_head_disk_address_unit
(
    input  logic                         clk,
    input  logic                         rst_n,

    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,

    // request channel
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [2:0]                   action,
    input  logic [7:0]                   address_high,
    input  logic [7:0]                   address_low,
    input  logic [6:0]                   current_sector,

    // response channel
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [fhdau_pkg::WADDR_W-1:0] word_address,
    output logic                         bad_address,
    output logic                         write_protected,
    output logic                         track_overflow,
    output logic [7:0]                   address_byte_high,
    output logic [7:0]                   address_byte_low,
    output logic [6:0]                   sector_byte,
    output logic [fhdau_pkg::SLEN_W-1:0] sense_length,
    output logic [7:0]                   device_status
);

    import fhdau_pkg::*;

    localparam int IDX_W   = 17;                            // track * sectors + sector
    localparam int WPS_W   = $clog2(WORDS_PER_SECTOR + 1);
    localparam int PROD_W  = IDX_W + WPS_W;
    localparam int LG_W    = $clog2(LOCK_GROUPS + 1);
    localparam int GPROD_W = TRK_W + LG_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic              model_reg;
    logic [LOCK_W-1:0] write_lock_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg      <= 1'b0;
            write_lock_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_MODEL:      model_reg      <= pwdata[0];
                REG_WRITE_LOCK: write_lock_reg <= pwdata[LOCK_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MODEL:      prdata = {31'd0, model_reg};
            REG_WRITE_LOCK: prdata = {16'd0, write_lock_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Request register and handshake
    // ---------------------------------------------------------------
    logic       s1_valid_reg;
    logic [2:0] s1_action_reg;
    logic [7:0] s1_hi_reg;
    logic [7:0] s1_lo_reg;
    logic [6:0] s1_cur_reg;
    logic       rsp_valid_reg;
    logic       advance;
    logic       req_take;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || !rsp_valid_reg || rsp_ready;
    assign req_take  = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_action_reg <= action;
            s1_hi_reg     <= address_high;
            s1_lo_reg     <= address_low;
            s1_cur_reg    <= current_sector;
        end
    end

    // ---------------------------------------------------------------
    // Address state and action logic
    // ---------------------------------------------------------------
    logic [ADDR_W-1:0] disk_address_reg;
    logic [ADDR_W-1:0] disk_address_next;
    logic              protect_flag_reg;
    logic              protect_flag_next;

    function automatic logic [TRK_W-1:0] get_track(input logic [ADDR_W-1:0] a, input logic m);
        get_track = m ? a[13:4] : {2'b00, a[14:7]};
    endfunction

    function automatic logic [SEC_W-1:0] get_sector(input logic [ADDR_W-1:0] a, input logic m);
        get_sector = m ? {3'b000, a[3:0]} : a[6:0];
    endfunction

    function automatic logic addr_bad(input logic [ADDR_W-1:0] a, input logic m);
        logic [TRK_W-1:0] t;
        logic [SEC_W-1:0] s;
        t = get_track(a, m);
        s = get_sector(a, m);
        if (m)
            addr_bad = (t >= TRK_W'(M1_TRACKS)) || (s >= SEC_W'(M1_SECTORS));
        else
            addr_bad = (t >= TRK_W'(M0_TRACKS)) || (s >= SEC_W'(M0_SECTORS));
    endfunction

    logic [TRK_W-1:0]   cur_track;
    logic [SEC_W-1:0]   cur_sector;
    logic               cur_bad;
    logic [IDX_W-1:0]   sec_index;
    logic [PROD_W-1:0]  word_prod;
    logic [GPROD_W-1:0] grp_prod;
    logic [GPROD_W-1:0] grp;
    logic               locked;

    // advance
    logic [SEC_W:0]     adv_sec;
    logic               adv_wrap;
    logic [TRK_W:0]     adv_trk;
    logic [SEC_W-1:0]   adv_sec_w;
    logic [ADDR_W-1:0]  adv_addr;
    logic               adv_ovf;

    assign cur_track  = get_track(disk_address_reg, model_reg);
    assign cur_sector = get_sector(disk_address_reg, model_reg);
    assign cur_bad    = addr_bad(disk_address_reg, model_reg);

    // Sector index in the disk; constant multiplies per geometry
    always_comb
    begin
        if (model_reg)
            sec_index = IDX_W'(cur_track) * IDX_W'(M1_SECTORS) + IDX_W'(cur_sector);
        else
            sec_index = IDX_W'(cur_track) * IDX_W'(M0_SECTORS) + IDX_W'(cur_sector);
    end

    assign word_prod = PROD_W'(sec_index) * PROD_W'(WORDS_PER_SECTOR);

    // Lock group = track * LOCK_GROUPS / tracks; tracks is a power of two
    assign grp_prod = GPROD_W'(cur_track) * GPROD_W'(LOCK_GROUPS);
    assign grp      = model_reg ? (grp_prod >> $clog2(M1_TRACKS))
                                : (grp_prod >> $clog2(M0_TRACKS));
    assign locked   = (grp < GPROD_W'(LOCK_W)) && write_lock_reg[grp[3:0]];

    // Sector step; a sector at or past the limit wraps into the next track
    always_comb
    begin
        adv_sec  = {1'b0, cur_sector} + 1'b1;
        if (model_reg)
            adv_wrap = adv_sec >= (SEC_W+1)'(M1_SECTORS);
        else
            adv_wrap = adv_sec >= (SEC_W+1)'(M0_SECTORS);
        adv_trk   = {1'b0, cur_track} + {{TRK_W{1'b0}}, adv_wrap};
        adv_sec_w = adv_wrap ? '0 : adv_sec[SEC_W-1:0];
        if (model_reg)
        begin
            adv_addr = {adv_trk[10:0], adv_sec_w[3:0]};
            adv_ovf  = adv_trk >= (TRK_W+1)'(M1_TRACKS);
        end
        else
        begin
            adv_addr = {adv_trk[7:0], adv_sec_w};
            adv_ovf  = adv_trk >= (TRK_W+1)'(M0_TRACKS);
        end
    end

    // Response fields
    logic [WADDR_W-1:0] wa_next;
    logic               wp_next;
    logic               ovf_next;
    logic [7:0]         abh_next;
    logic [7:0]         abl_next;
    logic [6:0]         sb_next;
    logic [SLEN_W-1:0]  slen_next;
    logic               bad_next;

    always_comb
    begin
        disk_address_next = disk_address_reg;
        protect_flag_next = protect_flag_reg;
        wa_next           = '0;
        wp_next           = 1'b0;
        ovf_next          = 1'b0;
        abh_next          = '0;
        abl_next          = '0;
        sb_next           = '0;
        slen_next         = '0;
        case (s1_action_reg)
            ACT_START:
            begin
                protect_flag_next = 1'b0;
            end
            ACT_SEEK:
            begin
                disk_address_next = {s1_hi_reg[6:0], s1_lo_reg};
            end
            ACT_XLATE:
            begin
                if (!cur_bad)
                    wa_next = word_prod[WADDR_W-1:0];
            end
            ACT_XLATE_WR:
            begin
                // lock test first: a locked group refuses even a bad address
                if (locked)
                begin
                    protect_flag_next = 1'b1;
                    wp_next           = 1'b1;
                end
                else if (!cur_bad)
                begin
                    wa_next = word_prod[WADDR_W-1:0];
                end
            end
            ACT_ADVANCE:
            begin
                disk_address_next = adv_addr;
                ovf_next          = adv_ovf;
            end
            ACT_SENSE:
            begin
                abh_next  = {cur_bad, disk_address_reg[14:8]};
                abl_next  = disk_address_reg[7:0];
                sb_next   = s1_cur_reg;
                slen_next = model_reg ? SENSE_LEN_M1 : SENSE_LEN_M0;
            end
            default:
            begin
            end
        endcase
        bad_next = addr_bad(disk_address_next, model_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_address_reg <= '0;
            protect_flag_reg <= 1'b0;
        end
        else if (advance)
        begin
            disk_address_reg <= disk_address_next;
            protect_flag_reg <= protect_flag_next;
        end
    end

    // ---------------------------------------------------------------
    // Response register
    // ---------------------------------------------------------------
    logic [WADDR_W-1:0] wa_reg;
    logic               bad_reg;
    logic               wp_reg;
    logic               ovf_reg;
    logic [7:0]         abh_reg;
    logic [7:0]         abl_reg;
    logic [6:0]         sb_reg;
    logic [SLEN_W-1:0]  slen_reg;
    logic               prot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            wa_reg   <= wa_next;
            bad_reg  <= bad_next;
            wp_reg   <= wp_next;
            ovf_reg  <= ovf_next;
            abh_reg  <= abh_next;
            abl_reg  <= abl_next;
            sb_reg   <= sb_next;
            slen_reg <= slen_next;
            prot_reg <= protect_flag_next;
        end
    end

    assign rsp_valid         = rsp_valid_reg;
    assign word_address      = wa_reg;
    assign bad_address       = bad_reg;
    assign write_protected   = wp_reg;
    assign track_overflow    = ovf_reg;
    assign address_byte_high = abh_reg;
    assign address_byte_low  = abl_reg;
    assign sector_byte       = sb_reg;
    assign sense_length      = slen_reg;
    assign device_status     = {2'b00, bad_reg, prot_reg, 4'b0000};

endmodule

>>> hdl/fhdau_checker.sv
`timescale 1ns / 1ps

module fhdau_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [fhdau_pkg::WADDR_W-1:0] word_address,
    input logic                          bad_address,
    input logic                          write_protected,
    input logic                          track_overflow,
    input logic [7:0]                    address_byte_high,
    input logic [fhdau_pkg::SLEN_W-1:0]  sense_length,
    input logic [7:0]                    device_status
);

    import fhdau_pkg::*;

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(word_address)
            && $stable(device_status))
        else $error("response changed while stalled");

    // status byte mirrors the bad-address bit; a bad address never translates
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> device_status[STAT_BAD_BIT] == bad_address
            && device_status[7:6] == 2'b00 && device_status[3:0] == 4'b0000
            && (!bad_address || word_address == '0))
        else $error("status byte inconsistent");

    a_protect: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && write_protected |-> device_status[STAT_PROTECT_BIT]
            && word_address == '0 && !track_overflow && sense_length == '0)
        else $error("refused write with stray fields");

    a_sense: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && sense_length != '0 |->
            (sense_length == SENSE_LEN_M0 || sense_length == SENSE_LEN_M1)
            && address_byte_high[7] == bad_address && word_address == '0)
        else $error("sense response malformed");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && track_overflow |-> word_address == '0
            && sense_length == '0 && address_byte_high == 8'd0)
        else $error("overflow with stray fields");

endmodule

bind fixed_head_disk_address_unit fhdau_checker u_fhdau_checker (.*);

>>> bench/fixed_head_disk_address_unit_test.sv
`timescale 1ns / 1ps

// Request/response bench for the head-per-track disk address unit.
module fixed_head_disk_address_unit_test;
    import fhdau_pkg::*;

    // Action codes the package leaves unnamed: they must change nothing.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    // Register byte addresses on the config port (4 bytes apart).
    localparam logic [2:0] MODEL_ADDR = {REG_MODEL, 2'b00};
    localparam logic [2:0] LOCK_ADDR  = {REG_WRITE_LOCK, 2'b00};

    // Quiet cycles with no accepted request or response before giving up.
    // Longest legit quiet stretch: the receiver hold-off plus a drain and a
    // register write, so this is many times over.
    localparam int QUIET_LIMIT = 4000;
    localparam int PIPE_CYCLES = 4;     // two-stage pipe plus margin
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [2:0] action;
        logic [7:0] address_high;
        logic [7:0] address_low;
        logic [6:0] current_sector;
    } disk_request_t;

    typedef struct {
        logic [WADDR_W-1:0] word_address;
        logic               bad_address;
        logic               write_protected;
        logic               track_overflow;
        logic [7:0]         address_byte_high;
        logic [7:0]         address_byte_low;
        logic [6:0]         sector_byte;
        logic [SLEN_W-1:0]  sense_length;
        logic [7:0]         device_status;
    } disk_response_t;

    // Keeps its own copy of the address register, the sticky protect flag
    // and the two config registers; each accepted request is run through
    // them right away and the response it must produce is queued.
    class status_scoreboard;
        bit                model_sel;
        bit [LOCK_W-1:0]   lock_mask;
        bit [ADDR_W-1:0]   disk_addr;
        bit                protect_flag;
        disk_response_t    pending_responses[$];
        int                failures;
        int                checked;
        int                requests;
        int                overflows;
        int                refusals;
        int                bad_seen;
        int                action_seen[8];

        function void set_register(logic [2:0] addr, logic [31:0] data);
            if (addr == MODEL_ADDR)
                model_sel = data[0];
            else if (addr == LOCK_ADDR)
                lock_mask = data[LOCK_W-1:0];
        endfunction

        function int unsigned track_of();
            return model_sel ? int'(disk_addr[13:4]) : int'(disk_addr[14:7]);
        endfunction

        function int unsigned sector_of();
            return model_sel ? int'(disk_addr[3:0]) : int'(disk_addr[6:0]);
        endfunction

        function int unsigned sectors();
            return model_sel ? M1_SECTORS : M0_SECTORS;
        endfunction

        function int unsigned tracks();
            return model_sel ? M1_TRACKS : M0_TRACKS;
        endfunction

        function bit out_of_range();
            return track_of() >= tracks() || sector_of() >= sectors();
        endfunction

        function logic [WADDR_W-1:0] first_word();
            int unsigned w;
            w = (track_of() * sectors() + sector_of()) * WORDS_PER_SECTOR;
            return w[WADDR_W-1:0];
        endfunction

        function disk_response_t apply_request(disk_request_t r);
            disk_response_t rsp;
            int unsigned    group;
            int unsigned    trk;
            int unsigned    sec;
            int unsigned    next_addr;
            rsp = '{default: '0};
            case (r.action)
                ACT_START:
                    protect_flag = 1'b0;
                ACT_SEEK:
                    disk_addr = {r.address_high[6:0], r.address_low};
                ACT_XLATE:
                    if (!out_of_range())
                        rsp.word_address = first_word();
                ACT_XLATE_WR:
                begin
                    // lock is tested before the range check; high groups
                    // have no switch
                    group = track_of() * LOCK_GROUPS / tracks();
                    if (group < LOCK_W && lock_mask[group])
                    begin
                        protect_flag = 1'b1;
                        rsp.write_protected = 1'b1;
                    end
                    else if (!out_of_range())
                        rsp.word_address = first_word();
                end
                ACT_ADVANCE:
                begin
                    // a sector at or past the limit wraps too
                    trk = track_of();
                    sec = sector_of() + 1;
                    if (sec >= sectors())
                    begin
                        sec = 0;
                        trk = trk + 1;
                    end
                    next_addr = model_sel ? ((trk << 4) | sec) : ((trk << 7) | sec);
                    disk_addr = next_addr[ADDR_W-1:0];
                    rsp.track_overflow = (trk >= tracks());
                end
                ACT_SENSE:
                begin
                    rsp.address_byte_high = {out_of_range(), disk_addr[14:8]};
                    rsp.address_byte_low  = disk_addr[7:0];
                    rsp.sector_byte       = r.current_sector;
                    rsp.sense_length      = model_sel ? SENSE_LEN_M1 : SENSE_LEN_M0;
                end
                default: ;
            endcase
            rsp.bad_address = out_of_range();
            rsp.device_status[STAT_PROTECT_BIT] = protect_flag;
            rsp.device_status[STAT_BAD_BIT]     = rsp.bad_address;
            return rsp;
        endfunction

        function void note_request(disk_request_t r);
            disk_response_t rsp;
            rsp = apply_request(r);
            pending_responses.push_back(rsp);
            requests++;
            action_seen[r.action]++;
            overflows += rsp.track_overflow;
            refusals  += rsp.write_protected;
            bad_seen  += rsp.bad_address;
        endfunction

        function void check_response(disk_response_t got);
            disk_response_t exp;
            if (pending_responses.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: response with nothing outstanding, st=%h",
                             got.device_status);
                return;
            end
            exp = pending_responses.pop_front();
            checked++;
            if (got.word_address      !== exp.word_address      ||
                got.bad_address       !== exp.bad_address       ||
                got.write_protected   !== exp.write_protected   ||
                got.track_overflow    !== exp.track_overflow    ||
                got.address_byte_high !== exp.address_byte_high ||
                got.address_byte_low  !== exp.address_byte_low  ||
                got.sector_byte       !== exp.sector_byte       ||
                got.sense_length      !== exp.sense_length      ||
                got.device_status     !== exp.device_status)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $display("ERROR: response %0d exp wa=%h bad=%b wp=%b ovf=%b ab=%h%h sb=%h len=%0d st=%h",
                             checked, exp.word_address, exp.bad_address,
                             exp.write_protected, exp.track_overflow,
                             exp.address_byte_high, exp.address_byte_low,
                             exp.sector_byte, exp.sense_length, exp.device_status);
                    $display("       response %0d got wa=%h bad=%b wp=%b ovf=%b ab=%h%h sb=%h len=%0d st=%h",
                             checked, got.word_address, got.bad_address,
                             got.write_protected, got.track_overflow,
                             got.address_byte_high, got.address_byte_low,
                             got.sector_byte, got.sense_length, got.device_status);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                req_valid;
    logic                req_ready;
    logic [2:0]          action;
    logic [7:0]          address_high;
    logic [7:0]          address_low;
    logic [6:0]          current_sector;
    logic                rsp_valid;
    logic                rsp_ready;
    logic [WADDR_W-1:0]  word_address;
    logic                bad_address;
    logic                write_protected;
    logic                track_overflow;
    logic [7:0]          address_byte_high;
    logic [7:0]          address_byte_low;
    logic [6:0]          sector_byte;
    logic [SLEN_W-1:0]   sense_length;
    logic [7:0]          device_status;

    status_scoreboard    sb;
    int                  quiet_cycles;
    int                  rsp_hold_left;     // long receiver hold-off, in cycles
    bit                  cur_model;         // geometry the stimulus aims at
    bit                  sender_gaps;       // off: back-to-back requests
    int                  burst_left;

    fixed_head_disk_address_unit u_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .req_valid         (req_valid),
        .req_ready         (req_ready),
        .action            (action),
        .address_high      (address_high),
        .address_low       (address_low),
        .current_sector    (current_sector),
        .rsp_valid         (rsp_valid),
        .rsp_ready         (rsp_ready),
        .word_address      (word_address),
        .bad_address       (bad_address),
        .write_protected   (write_protected),
        .track_overflow    (track_overflow),
        .address_byte_high (address_byte_high),
        .address_byte_low  (address_byte_low),
        .sector_byte       (sector_byte),
        .sense_length      (sense_length),
        .device_status     (device_status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Both channels are sampled at the rising edge. The response is checked
    // before the request of the same edge is noted; with the request and
    // response registers between them they can never belong together anyway.
    always @(posedge clk)
    begin : monitor
        disk_response_t got;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                got.word_address      = word_address;
                got.bad_address       = bad_address;
                got.write_protected   = write_protected;
                got.track_overflow    = track_overflow;
                got.address_byte_high = address_byte_high;
                got.address_byte_low  = address_byte_low;
                got.sector_byte       = sector_byte;
                got.sense_length      = sense_length;
                got.device_status     = device_status;
                sb.check_response(got);
            end
            if (req_valid && req_ready)
                sb.note_request('{action, address_high, address_low, current_sector});
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Timeout: %0d cycles with no traffic", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Receiver: a long hold-off when asked for, otherwise a pattern that
    // steps through four modes: always ready, coin flip, 3 of 4, rarely ready.
    initial
    begin : receiver
        int cyc;
        cyc = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (rsp_hold_left > 0)
            begin
                rsp_ready = 1'b0;
                rsp_hold_left--;
            end
            else
                case ((cyc / 97) % 4)
                    0: rsp_ready = 1'b1;
                    1: rsp_ready = 1'($urandom_range(0, 1));
                    2: rsp_ready = (cyc % 4 != 3);
                    default: rsp_ready = ($urandom_range(0, 7) == 0);
                endcase
        end
    end

    // One request: drive at the falling edge, hold until taken. Between
    // bursts the sender idles for a random gap unless gaps are off.
    task automatic send_request(input logic [2:0] act, input logic [7:0] hi,
                                input logic [7:0] lo, input logic [6:0] cur);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps)
            begin
                gap = $urandom_range(1, 6);
                @(negedge clk);
                req_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid      = 1'b1;
        action         = act;
        address_high   = hi;
        address_low    = lo;
        current_sector = cur;
        do @(posedge clk); while (!req_ready);
    endtask

    // Stop offering and wait until every queued response has come back.
    task automatic drain();
        @(negedge clk);
        req_valid = 1'b0;
        while (sb.pending_responses.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(addr, data);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic reconfigure(input bit m, input logic [15:0] lock);
        drain();
        write_register(MODEL_ADDR, {31'd0, m});
        write_register(LOCK_ADDR, {16'd0, lock});
        cur_model = m;
    endtask

    // Seek to a track/sector of the current geometry. Bit 7 of the high
    // byte is ignored by the unit; bit 14 plays no part in model 1 geometry.
    task automatic seek_to(input int unsigned trk, input int unsigned sec);
        logic [14:0] addr;
        if (cur_model)
        begin
            addr = 15'((trk << 4) | sec);
            addr[14] = 1'($urandom_range(0, 1));
        end
        else
            addr = 15'((trk << 7) | sec);
        send_request(ACT_SEEK, {1'($urandom_range(0, 1)), addr[14:8]}, addr[7:0],
                     7'($urandom_range(0, 127)));
    endtask

    // Mostly well-formed runs: a seek to a mostly good address, near the
    // end of the disk or the track often, then a string of operations on it.
    // The rest is noise over all eight action codes and every field bit.
    task automatic run_random(input int count, input int hold_at);
        int          sent;
        int          ops;
        int unsigned trk;
        int unsigned sec;
        int unsigned ntrk;
        int unsigned nsec;
        logic [2:0]  op;
        sent = 0;
        ntrk = cur_model ? M1_TRACKS : M0_TRACKS;
        nsec = cur_model ? M1_SECTORS : M0_SECTORS;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: trk = ntrk - 1 - $urandom_range(0, 1);
                    3:       trk = cur_model ? $urandom_range(0, 1023)
                                             : $urandom_range(0, 255);
                    default: trk = $urandom_range(0, ntrk - 1);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2: sec = nsec - 1 - $urandom_range(0, 1);
                    3:       sec = cur_model ? $urandom_range(0, 15)
                                             : $urandom_range(0, 127);
                    default: sec = $urandom_range(0, nsec - 1);
                endcase
                seek_to(trk, sec);
                sent++;
                if (sent == hold_at)
                    rsp_hold_left = 90;
                ops = $urandom_range(3, 10);
                repeat (ops)
                begin
                    case ($urandom_range(0, 8))
                        0:          op = ACT_START;
                        1:          op = ACT_XLATE;
                        2, 3:       op = ACT_XLATE_WR;
                        4:          op = ACT_SENSE;
                        default:    op = ACT_ADVANCE;
                    endcase
                    send_request(op, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)),
                                 7'($urandom_range(0, 127)));
                    sent++;
                    if (sent == hold_at)
                        rsp_hold_left = 90;
                end
            end
            else
            begin
                send_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
                sent++;
            end
            if (sent == hold_at)
                rsp_hold_left = 90;
        end
    endtask

    initial
    begin : main
        sb            = new();
        quiet_cycles  = 0;
        rsp_hold_left = 0;
        burst_left    = 0;
        sender_gaps   = 1'b0;
        cur_model     = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_valid      = 1'b0;
        action         = ACT_START;
        address_high   = '0;
        address_low    = '0;
        current_sector = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, model 0: group 0 and group 15 locked.
        reconfigure(1'b0, 16'h8001);
        send_request(ACT_START,    8'h00, 8'h00, 7'd0);
        send_request(ACT_SEEK,     8'h00, 8'h00, 7'd0);
        send_request(ACT_XLATE,    8'h00, 8'h00, 7'd0);
        send_request(ACT_XLATE_WR, 8'h00, 8'h00, 7'd0);   // refused, flag set
        send_request(ACT_SENSE,    8'h00, 8'h00, 7'd127); // sector echoed as is
        send_request(ACT_START,    8'hFF, 8'hFF, 7'd0);   // flag cleared
        send_request(ACT_SEEK,     8'hFF, 8'hFF, 7'd0);   // track 255, sector 127
        send_request(ACT_XLATE,    8'h00, 8'h00, 7'd0);
        send_request(ACT_XLATE_WR, 8'h00, 8'h00, 7'd0);   // group past the switches
        send_request(ACT_ADVANCE,  8'h00, 8'h00, 7'd0);   // bad sector wraps, overflow
        send_request(ACT_SEEK,     8'h1F, 8'hD1, 7'd0);   // last track, last sector
        send_request(ACT_XLATE,    8'h00, 8'h00, 7'd0);
        send_request(ACT_ADVANCE,  8'h00, 8'h00, 7'd0);   // past the last track
        send_request(ACT_SENSE,    8'h00, 8'h00, 7'd0);
        send_request(ACT_SPARE_6,  8'hFF, 8'hFF, 7'd127);
        send_request(ACT_SPARE_7,  8'h80, 8'h55, 7'd81);
        send_request(ACT_SEEK,     8'h1F, 8'hE4, 7'd0);   // locked group, bad sector
        send_request(ACT_XLATE_WR, 8'h00, 8'h00, 7'd0);   // lock wins over range
        send_request(ACT_SENSE,    8'h00, 8'h00, 7'd64);

        // Directed, model 1: model write keeps the address and the flag.
        reconfigure(1'b1, 16'h8001);
        send_request(ACT_SENSE,    8'h00, 8'h00, 7'd11);
        send_request(ACT_SEEK,     8'h1F, 8'hFB, 7'd0);   // track 511, sector 11
        send_request(ACT_XLATE,    8'h00, 8'h00, 7'd0);   // largest word address
        send_request(ACT_ADVANCE,  8'h00, 8'h00, 7'd0);   // past the last track
        send_request(ACT_SEEK,     8'h7F, 8'hFF, 7'd0);   // track 1023, sector 15
        send_request(ACT_XLATE_WR, 8'h00, 8'h00, 7'd0);
        send_request(ACT_ADVANCE,  8'h00, 8'h00, 7'd0);
        send_request(ACT_SENSE,    8'h00, 8'h00, 7'd5);

        // Random phases over both geometries and the lock extremes. The
        // third phase holds the receiver off long enough to back up the
        // input; every phase ends with a full drain before the next write.
        sender_gaps = 1'b1;
        reconfigure(1'b0, 16'h0000);
        run_random(200, -1);
        reconfigure(1'b1, 16'hFFFF);
        run_random(200, -1);
        reconfigure(1'b0, 16'($urandom_range(0, 16'hFFFF)));
        run_random(200, 40);
        sender_gaps = 1'b0;
        reconfigure(1'b1, 16'($urandom_range(0, 16'hFFFF)));
        run_random(200, -1);
        sender_gaps = 1'b1;
        reconfigure(1'b0, 16'hFFFF);
        run_random(200, -1);
        reconfigure(1'b1, 16'h0000);
        run_random(200, -1);

        drain();
        repeat (PIPE_CYCLES) @(posedge clk);

        $display("Covered %0d requests over both geometries and six lock settings;",
                 sb.requests);
        $display("%0d responses checked, %0d overflows, %0d write refusals, %0d bad addresses",
                 sb.checked, sb.overflows, sb.refusals, sb.bad_seen);
        if (sb.failures == 0 && sb.pending_responses.size() == 0)
            $display("All tests passed");
        else
        begin
            $display("%0d mismatches, %0d responses still outstanding",
                     sb.failures, sb.pending_responses.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
